/* rtl/sdtp_pkg.sv */
// Package for the SDT section parser: record types, status codes, phases
// and the byte-wide MPEG-2 CRC-32 step. No dependencies.
`default_nettype none
package sdtp_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [7:0]  TID_SDT_ACT = 8'h42;
  localparam logic [7:0]  TID_SDT_OTH = 8'h46;

  typedef enum logic [1:0] {
    REC_HEADER  = 2'd0,
    REC_SERVICE = 2'd1,
    REC_STATUS  = 2'd2
  } rec_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SYNTAX    = 3'd1,
    ST_TABLE_ID  = 3'd2,
    ST_SIZE      = 3'd3,
    ST_CRC       = 3'd4,
    ST_TOO_SHORT = 3'd5
  } status_t;

  typedef enum logic {
    PH_PARSE = 1'b0,
    PH_DRAIN = 1'b1
  } phase_t;

  typedef struct packed {
    rec_kind_t   kind;
    logic [15:0] first_id;
    logic [15:0] second_id;
    logic [4:0]  ver_num;
    logic        current_next;
    logic [7:0]  sect_num;
    logic [7:0]  last_sect_num;
    logic [4:0]  eit_flags;
    logic [2:0]  run_state;
    logic        ca_flag;
    status_t     status;
    logic        last_of_run;
  } rec_t;

  // up to two records per accepted byte; r0 goes out first
  typedef struct packed {
    logic v0;
    logic v1;
    rec_t r0;
    rec_t r1;
  } push_t;

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/sdtp_parse.sv */
// Section parser core: per-byte state, CRC and record building.
// Depends on sdtp_pkg.
`default_nettype none
module sdtp_parse (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                accept,
  input  wire  [7:0]         data_byte,
  input  wire                byte_last,
  output sdtp_pkg::push_t    push
);
  import sdtp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [12:0] pos_r, pos_nxt;
  logic [11:0] len_r, len_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [2:0]  ent_r, ent_nxt;
  logic [11:0] skip_r, skip_nxt;
  logic [15:0] id_r, id_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [7:0]  stat_r, stat_nxt;
  logic [37:0] hdr_r, hdr_nxt;
  logic        hsent_r, hsent_nxt;
  logic [7:0]  tid_r, tid_nxt;

  logic [31:0] crc_upd;
  logic [12:0] sec_end;
  logic [12:0] crc_start;
  logic        fin;
  status_t     code;
  logic        emit_a;
  rec_t        rec_a;
  rec_t        rec_s;
  logic [11:0] dll;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    ent_nxt   = ent_r;
    skip_nxt  = skip_r;
    id_nxt    = id_r;
    flags_nxt = flags_r;
    stat_nxt  = stat_r;
    hdr_nxt   = hdr_r;
    hsent_nxt = hsent_r;
    tid_nxt   = tid_r;
    fin       = 1'b0;
    code      = ST_OK;
    emit_a    = 1'b0;
    rec_a     = '0;
    rec_s     = '0;
    crc_upd   = crc_step(crc_r, data_byte);
    sec_end   = {1'b0, len_r} + 13'd2;
    crc_start = {1'b0, len_r} - 13'd1;
    dll       = {stat_r[3:0], data_byte};

    if (phase_r == PH_DRAIN) begin
      if (byte_last) begin
        phase_nxt = PH_PARSE;
      end
    end else begin
      crc_nxt = crc_upd;
      if (byte_last && pos_r <= 13'd5) begin
        fin  = 1'b1;
        code = ST_TOO_SHORT;
      end else if (pos_r == 13'd0) begin
        tid_nxt = data_byte;
      end else if (pos_r == 13'd1) begin
        if (!data_byte[7]) begin
          fin  = 1'b1;
          code = ST_SYNTAX;
        end else if (tid_r != TID_SDT_ACT && tid_r != TID_SDT_OTH) begin
          fin  = 1'b1;
          code = ST_TABLE_ID;
        end else begin
          len_nxt = {data_byte[3:0], 8'h00};
        end
      end else if (pos_r == 13'd2) begin
        len_nxt = {len_r[11:8], data_byte};
        if (len_nxt <= 12'd4) begin
          fin  = 1'b1;
          code = ST_SIZE;
        end
      end else begin
        case (pos_r)
          13'd3: hdr_nxt[37:30] = hdr_r[37:30] | data_byte;
          13'd4: hdr_nxt[29:22] = hdr_r[29:22] | data_byte;
          13'd5: hdr_nxt[21:16] = hdr_r[21:16] | data_byte[5:0];
          13'd6: hdr_nxt[15:8]  = hdr_r[15:8] | data_byte;
          13'd7: hdr_nxt[7:0]   = hdr_r[7:0] | data_byte;
          13'd8: id_nxt = {data_byte, 8'h00};
          13'd9: begin
            id_nxt    = id_r | {8'h00, data_byte};
            emit_a    = 1'b1;
            hsent_nxt = 1'b1;
          end
          13'd10: ;
          default: begin
            if (skip_r != 12'd0) begin
              skip_nxt = skip_r - 12'd1;
            end else if (ent_r != 3'd0 || pos_r < crc_start) begin
              ent_nxt = ent_r + 3'd1;
              case (ent_r)
                3'd0: id_nxt = {data_byte, 8'h00};
                3'd1: id_nxt = {id_r[15:8], data_byte};
                3'd2: flags_nxt = data_byte;
                3'd3: stat_nxt = data_byte;
                default: begin
                  emit_a          = 1'b1;
                  rec_a.kind      = REC_SERVICE;
                  rec_a.first_id  = id_r;
                  rec_a.second_id = {4'h0, dll};
                  rec_a.eit_flags = flags_r[4:0];
                  rec_a.run_state = stat_r[7:5];
                  rec_a.ca_flag   = stat_r[4];
                  skip_nxt        = dll;
                  ent_nxt         = 3'd0;
                end
              endcase
            end
          end
        endcase
        if (pos_r == sec_end) begin
          // short section: header goes out just ahead of the status
          if (!hsent_r) begin
            emit_a = 1'b1;
          end
          fin  = 1'b1;
          code = (crc_upd == 32'h0) ? ST_OK : ST_CRC;
        end else if (byte_last) begin
          fin  = 1'b1;
          code = ST_SIZE;
        end
        if (emit_a && (pos_r <= 13'd9)) begin
          rec_a.kind          = REC_HEADER;
          rec_a.first_id      = hdr_nxt[37:22];
          rec_a.second_id     = id_nxt;
          rec_a.ver_num       = hdr_nxt[21:17];
          rec_a.current_next  = hdr_nxt[16];
          rec_a.sect_num      = hdr_nxt[15:8];
          rec_a.last_sect_num = hdr_nxt[7:0];
        end
      end

      if (fin) begin
        phase_nxt = byte_last ? PH_PARSE : PH_DRAIN;
      end else if (pos_r != 13'h1FFF) begin
        pos_nxt = pos_r + 13'd1;
      end
    end

    // a finished section, or the end of a drained one, clears section state
    if (fin || (phase_r == PH_DRAIN && byte_last)) begin
      pos_nxt   = '0;
      len_nxt   = '0;
      crc_nxt   = '1;
      ent_nxt   = '0;
      skip_nxt  = '0;
      id_nxt    = '0;
      flags_nxt = '0;
      stat_nxt  = '0;
      hdr_nxt   = '0;
      hsent_nxt = 1'b0;
      tid_nxt   = '0;
    end

    rec_s.kind        = REC_STATUS;
    rec_s.status      = code;
    rec_s.last_of_run = 1'b1;
    rec_a.last_of_run = !fin;

    push.v0 = accept && (emit_a || fin);
    push.v1 = accept && emit_a && fin;
    push.r0 = emit_a ? rec_a : rec_s;
    push.r1 = rec_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PARSE;
      pos_r   <= '0;
      len_r   <= '0;
      crc_r   <= '1;
      ent_r   <= '0;
      skip_r  <= '0;
      id_r    <= '0;
      flags_r <= '0;
      stat_r  <= '0;
      hdr_r   <= '0;
      hsent_r <= 1'b0;
      tid_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      ent_r   <= ent_nxt;
      skip_r  <= skip_nxt;
      id_r    <= id_nxt;
      flags_r <= flags_nxt;
      stat_r  <= stat_nxt;
      hdr_r   <= hdr_nxt;
      hsent_r <= hsent_nxt;
      tid_r   <= tid_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/sdtp_out_fifo.sv */
// Result queue: takes up to two records a cycle, hands out one.
// Depends on sdtp_pkg.
`default_nettype none
module sdtp_out_fifo (
  input  wire               clk,
  input  wire               rst_n,
  input  wire sdtp_pkg::push_t push,
  output logic              room,
  output logic              rd_valid,
  input  wire               rd_ready,
  output sdtp_pkg::rec_t    rd_rec
);
  import sdtp_pkg::*;

  rec_t             mem [QDEPTH];
  logic [QAW-1:0]   wr_r, wr_nxt;
  logic [QAW-1:0]   rd_r, rd_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             pop;
  logic [QAW-1:0]   wr_p1;

  assign rd_valid = (cnt_r != '0);
  assign rd_rec   = mem[rd_r];
  assign pop      = rd_valid && rd_ready;
  // two free slots cover the worst case of one byte
  assign room     = (cnt_r <= QCW'(QDEPTH - 2));
  assign wr_p1    = wr_r + QAW'(1);

  always_comb begin
    wr_nxt  = wr_r + QAW'(push.v0) + QAW'(push.v1);
    rd_nxt  = rd_r + QAW'(pop);
    cnt_nxt = cnt_r + QCW'(push.v0) + QCW'(push.v1) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_r] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/sdt_section_parser_top.sv */
// SDT section parser top: byte stream in, header/service/status records out.
// Depends on sdtp_pkg, sdtp_parse, sdtp_out_fifo.
//
//  channel  direction  tdata                          tuser        tlast
//  in_      slave      data_byte                      -            byte_last
//  out_     master     record fields (see out_tdata)  record_kind  last_of_run
//
// One byte per cycle; each byte is parsed in the cycle it is taken and its
// records (at most two) go into a four-entry result queue.
// in_tready drops only while the queue has fewer than two free entries,
// i.e. when out_tready has been low long enough for the queue to fill.
// Synchronous active-low reset empties the queue and returns to table id.
`default_nettype none
module sdt_section_parser_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [15:0] first_id, [31:16] second_id, [36:32] ver_num,
  // [37] current_next, [45:38] sect_num, [53:46] last_sect_num,
  // [58:54] eit_flags, [61:59] run_state, [62] ca_flag,
  // [65:63] status, [71:66] zero
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] record_kind
  output logic        out_tlast
);
  import sdtp_pkg::*;

  push_t push;
  rec_t  rec;
  logic  accept;

  assign accept = in_tvalid && in_tready;

  sdtp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_tdata),
    .byte_last (in_tlast),
    .push      (push)
  );

  sdtp_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (in_tready),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_rec   (rec)
  );

  assign out_tdata = {6'b0, rec.status, rec.ca_flag, rec.run_state,
                      rec.eit_flags, rec.last_sect_num, rec.sect_num,
                      rec.current_next, rec.ver_num, rec.second_id,
                      rec.first_id};
  assign out_tuser = rec.kind;
  assign out_tlast = rec.last_of_run;

`ifndef ASSERT_OFF
  a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == REC_STATUS |-> out_tlast)
    else $error("status record not last of run");

  a_status_zero_elsewhere: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != REC_STATUS |-> out_tdata[65:63] == 3'd0)
    else $error("status field set on non-status record");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid && in_tready)
    else $error("queue not empty after reset");
`endif

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Testbench for sdt_section_parser_top: SDT sections, broken sections and noise go in as
// a byte stream, and each record that comes out is checked against a local parser model.
// Depends on sdtp_pkg and the RTL of sdt_section_parser_top.
`timescale 1ns / 1ps
module tb_top;
  import sdtp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } sec_byte_t;

  typedef enum int {
    FAULT_NONE,
    FAULT_CRC,
    FAULT_SYNTAX,
    FAULT_TID,
    FAULT_SHORT_LEN,
    FAULT_LEN,
    FAULT_TRUNC,
    FAULT_DLL
  } fault_t;

  localparam int NUM_BYTES = 1900;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  sdt_section_parser_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  sec_byte_t  section_bytes[$];   // requests waiting for the driver
  logic [7:0] sec_bytes[$];       // section under construction
  rec_t       due_records[$];     // records the parser owes, oldest first
  rec_t       byte_recs[$];       // records caused by the current byte

  int fail_cnt = 0;
  int bytes_taken = 0;
  int recs_checked = 0;
  int hdr_cnt = 0;
  int svc_cnt = 0;
  int stat_cnt = 0;
  int clean_cnt = 0;

  // ---------------------------------------------------------------- parser model
  phase_t      sec_phase;
  logic [15:0] sec_pos;
  logic [15:0] sec_len;
  logic [31:0] sec_crc;
  logic [2:0]  ent_idx;
  logic [15:0] desc_skip;
  logic [15:0] held_id;
  logic [7:0]  held_flags;
  logic [7:0]  held_svc;
  logic [37:0] held_hdr;
  logic        hdr_sent;
  logic [7:0]  tid_seen;
  logic        closed_now;

  function automatic logic [31:0] crc32_mpeg(input logic [31:0] c, input logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = c[31] ^ b[k];
      c = {c[30:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task clear_section();
    sec_pos = '0;
    sec_len = '0;
    sec_crc = '1;
    ent_idx = '0;
    desc_skip = '0;
    held_id = '0;
    held_flags = '0;
    held_svc = '0;
    held_hdr = '0;
    hdr_sent = 1'b0;
    tid_seen = '0;
  endtask

  task emit_header();
    rec_t r;
    r = '0;
    r.kind = REC_HEADER;
    r.first_id = held_hdr[37:22];
    r.second_id = held_id;
    r.ver_num = held_hdr[21:17];
    r.current_next = held_hdr[16];
    r.sect_num = held_hdr[15:8];
    r.last_sect_num = held_hdr[7:0];
    byte_recs.insert(byte_recs.size(), r);
    hdr_sent = 1'b1;
  endtask

  task close_section(input status_t code, input logic lst);
    rec_t r;
    r = '0;
    r.kind = REC_STATUS;
    r.status = code;
    byte_recs.insert(byte_recs.size(), r);
    clear_section();
    sec_phase = lst ? PH_PARSE : PH_DRAIN;
    closed_now = 1'b1;
  endtask

  task service_byte(input logic [7:0] b);
    rec_t r;
    logic [15:0] dll;
    case (ent_idx)
      3'd0: held_id = {b, 8'h00};
      3'd1: held_id[7:0] = b;
      3'd2: held_flags = b;
      3'd3: held_svc = b;
      default: begin
        dll = {4'h0, held_svc[3:0], b};
        r = '0;
        r.kind = REC_SERVICE;
        r.first_id = held_id;
        r.second_id = dll;
        r.eit_flags = held_flags[4:0];
        r.run_state = held_svc[7:5];
        r.ca_flag = held_svc[4];
        byte_recs.insert(byte_recs.size(), r);
        desc_skip = dll;
        ent_idx = '0;
        return;
      end
    endcase
    ent_idx = ent_idx + 3'd1;
  endtask

  // Works out the records caused by one accepted byte and queues them.
  task parse_sdt_byte(input logic [7:0] b, input logic lst);
    logic [15:0] p;
    logic [15:0] sec_end;
    p = sec_pos;
    byte_recs.delete();
    closed_now = 1'b0;
    if (sec_phase != PH_PARSE) begin
      if (lst) begin
        sec_phase = PH_PARSE;
        clear_section();
      end
      return;
    end
    sec_crc = crc32_mpeg(sec_crc, b);
    if (lst && p <= 5) begin
      close_section(ST_TOO_SHORT, 1'b1);
    end else if (p == 0) begin
      tid_seen = b;
    end else if (p == 1) begin
      if (!b[7]) close_section(ST_SYNTAX, lst);
      else if (tid_seen != TID_SDT_ACT && tid_seen != TID_SDT_OTH)
        close_section(ST_TABLE_ID, lst);
      else sec_len = {4'h0, b[3:0], 8'h00};
    end else if (p == 2) begin
      sec_len[7:0] = b;
      if (sec_len <= 4) close_section(ST_SIZE, lst);
    end else begin
      sec_end = sec_len + 16'd2;
      case (p)
        16'd3: held_hdr[37:30] = b;
        16'd4: held_hdr[29:22] = b;
        16'd5: begin
          held_hdr[21:17] = b[5:1];
          held_hdr[16] = b[0];
        end
        16'd6: held_hdr[15:8] = b;
        16'd7: held_hdr[7:0] = b;
        16'd8: held_id = {b, 8'h00};
        16'd9: begin
          held_id[7:0] = b;
          emit_header();
        end
        16'd10: ;
        default: begin
          if (desc_skip > 0) desc_skip = desc_skip - 16'd1;
          else if (ent_idx > 0 || p < sec_len - 16'd1) service_byte(b);
        end
      endcase
      if (p == sec_end) begin
        if (!hdr_sent) emit_header();
        close_section(sec_crc == 0 ? ST_OK : ST_CRC, lst);
      end else if (lst) begin
        close_section(ST_SIZE, 1'b1);
      end
    end
    if (!closed_now && sec_pos < 16'd8191) sec_pos = sec_pos + 16'd1;
    if (byte_recs.size() > 0) byte_recs[byte_recs.size() - 1].last_of_run = 1'b1;
    foreach (byte_recs[i]) due_records.insert(due_records.size(), byte_recs[i]);
  endtask

  // ---------------------------------------------------------------- stimulus
  task add_byte(input logic [7:0] data, input logic last);
    sec_byte_t s;
    s.data = data;
    s.last = last;
    section_bytes.insert(section_bytes.size(), s);
  endtask

  // Patches the length field, appends the CRC, applies the fault and queues the bytes.
  task seal_section(input fault_t fault);
    logic [11:0] len_field;
    logic [31:0] crc;
    int keep;
    int idx;
    len_field = 12'(sec_bytes.size() + 1);
    case (fault)
      FAULT_SHORT_LEN: len_field = 12'($urandom_range(0, 4));
      FAULT_LEN: begin
        case ($urandom_range(0, 2))
          0: len_field = 12'($urandom_range(5, 9));
          1: len_field = 12'hFFF;
          default: len_field = 12'($urandom_range(5, len_field + 8));
        endcase
      end
      default: ;
    endcase
    sec_bytes[1] = {1'b1, 3'($urandom_range(0, 7)), len_field[11:8]};
    sec_bytes[2] = len_field[7:0];
    if (fault == FAULT_SYNTAX) sec_bytes[1] = sec_bytes[1] & 8'h7F;
    if (fault == FAULT_TID) begin
      do sec_bytes[0] = rand_byte();
      while (sec_bytes[0] == TID_SDT_ACT || sec_bytes[0] == TID_SDT_OTH);
    end
    crc = '1;
    foreach (sec_bytes[i]) crc = crc32_mpeg(crc, sec_bytes[i]);
    sec_bytes.insert(sec_bytes.size(), crc[31:24]);
    sec_bytes.insert(sec_bytes.size(), crc[23:16]);
    sec_bytes.insert(sec_bytes.size(), crc[15:8]);
    sec_bytes.insert(sec_bytes.size(), crc[7:0]);
    if (fault == FAULT_CRC) begin
      idx = $urandom_range(3, sec_bytes.size() - 1);
      sec_bytes[idx] = sec_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
    keep = sec_bytes.size();
    if (fault == FAULT_TRUNC) keep = $urandom_range(1, sec_bytes.size() - 1);
    for (idx = 0; idx < keep; idx++) add_byte(sec_bytes[idx], idx == keep - 1);
  endtask

  task queue_section(input logic [7:0] tid, input int n_svc, input int max_desc,
                     input fault_t fault);
    int dll;
    int body;
    sec_bytes.delete();
    sec_bytes.insert(sec_bytes.size(), tid);
    sec_bytes.insert(sec_bytes.size(), 8'h00);
    sec_bytes.insert(sec_bytes.size(), 8'h00);
    // header and reserved byte
    repeat (8) sec_bytes.insert(sec_bytes.size(), rand_byte());
    for (int s = 0; s < n_svc; s++) begin
      dll = $urandom_range(0, max_desc);
      // descriptor loop that does not match its declared length
      body = (fault == FAULT_DLL) ? $urandom_range(0, max_desc + 4) : dll;
      sec_bytes.insert(sec_bytes.size(), rand_byte());
      sec_bytes.insert(sec_bytes.size(), rand_byte());
      sec_bytes.insert(sec_bytes.size(), rand_byte());
      sec_bytes.insert(sec_bytes.size(), {3'($urandom_range(0, 7)),
                                          1'($urandom_range(0, 1)), 4'(dll >> 8)});
      sec_bytes.insert(sec_bytes.size(), 8'(dll));
      repeat (body) sec_bytes.insert(sec_bytes.size(), rand_byte());
    end
    seal_section(fault);
  endtask

  // ---------------------------------------------------------------- driver
  sec_byte_t next_byte;
  logic      byte_taken = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || byte_taken)) begin
      if (gap_left > 0 || section_bytes.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        next_byte = section_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= next_byte.data;
        in_tlast <= next_byte.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  logic [31:0] rx_cycle = '0;
  int          hold_left = 0;
  int          next_hold_at = 30;

  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 32'd1;
    if (hold_left == 0 && recs_checked >= next_hold_at) begin
      // long back-pressure: the result queue fills and in_tready must drop
      hold_left = 100;
      next_hold_at = next_hold_at + 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_cycle[9:8])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= 1'($urandom_range(0, 1));
        2'd2: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= (rx_cycle[2:0] >= 3'd3);
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor
  task cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  task check_record();
    rec_t want;
    if (due_records.size() == 0) begin
      $error("record with nothing due: kind %0d, tdata 0x%0h", out_tuser, out_tdata);
      fail_cnt++;
      return;
    end
    want = due_records.pop_front();
    recs_checked++;
    case (want.kind)
      REC_HEADER: hdr_cnt++;
      REC_SERVICE: svc_cnt++;
      default: begin
        stat_cnt++;
        if (want.status == ST_OK) clean_cnt++;
      end
    endcase
    cmp_field("record_kind", want.kind, out_tuser);
    cmp_field("first_id", want.first_id, out_tdata[15:0]);
    cmp_field("second_id", want.second_id, out_tdata[31:16]);
    cmp_field("ver_num", want.ver_num, out_tdata[36:32]);
    cmp_field("current_next", want.current_next, out_tdata[37]);
    cmp_field("sect_num", want.sect_num, out_tdata[45:38]);
    cmp_field("last_sect_num", want.last_sect_num, out_tdata[53:46]);
    cmp_field("eit_flags", want.eit_flags, out_tdata[58:54]);
    cmp_field("run_state", want.run_state, out_tdata[61:59]);
    cmp_field("ca_flag", want.ca_flag, out_tdata[62]);
    cmp_field("status", want.status, out_tdata[65:63]);
    cmp_field("last_of_run", want.last_of_run, out_tlast);
  endtask

  always @(posedge clk) begin
    byte_taken = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        byte_taken = 1'b1;
        bytes_taken++;
        parse_sdt_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) check_record();
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    fault_t fault;
    int roll;
    int n_svc;
    int max_desc;
    sec_phase = PH_PARSE;
    clear_section();

    // directed: too short on the first byte, bad syntax bit, bad table id,
    // length of four, then a good section with every field at its top value
    add_byte(TID_SDT_ACT, 1'b1);
    add_byte(TID_SDT_ACT, 1'b0);
    add_byte(8'h70, 1'b0);
    add_byte(8'hAA, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h00, 1'b1);
    add_byte(TID_SDT_OTH, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h04, 1'b0);
    add_byte(8'h5A, 1'b1);
    sec_bytes.delete();
    sec_bytes.insert(sec_bytes.size(), TID_SDT_OTH);
    sec_bytes.insert(sec_bytes.size(), 8'h00);
    sec_bytes.insert(sec_bytes.size(), 8'h00);
    // header plus one service, all ones
    repeat (13) sec_bytes.insert(sec_bytes.size(), 8'hFF);
    seal_section(FAULT_NONE);

    // random: well-formed and broken sections in about equal share, a little noise
    while (section_bytes.size() < NUM_BYTES) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        repeat ($urandom_range(0, 11)) add_byte(rand_byte(), 1'b0);
        add_byte(rand_byte(), 1'b1);
      end else begin
        fault = (roll < 55) ? FAULT_NONE : fault_t'($urandom_range(FAULT_CRC, FAULT_DLL));
        if ($urandom_range(0, 19) == 0) begin
          n_svc = $urandom_range(5, 12);
          max_desc = 60;
        end else begin
          n_svc = $urandom_range(0, 4);
          max_desc = 6;
        end
        queue_section($urandom_range(0, 1) ? TID_SDT_ACT : TID_SDT_OTH, n_svc, max_desc,
                      fault);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (section_bytes.size() != 0 || in_tvalid || due_records.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d bytes; checked %0d records: %0d headers, %0d services, %0d status",
             bytes_taken, recs_checked, hdr_cnt, svc_cnt, stat_cnt);
    $display("%0d sections ended clean, %0d with an error status",
             clean_cnt, stat_cnt - clean_cnt);
    if (fail_cnt == 0) begin
      $display("sdt_section_parser_top test passed");
    end else begin
      $display("sdt_section_parser_top test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d records still due", due_records.size());
    $display("sdt_section_parser_top test failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/sdtp_pkg.sv
rtl/sdtp_parse.sv
rtl/sdtp_out_fifo.sv
rtl/sdt_section_parser_top.sv
verif/tb_top.sv
